[sv/ilt_pkg.sv]
// ----------------------------------------------------------------------------
// ilt_pkg: shared types and constants for the INI line tokenizer
// Transfer structs, the command word passed from front to back, character
// and code constants, and the whitespace test.
// ----------------------------------------------------------------------------
package ilt_pkg;

    // Sizing
    localparam int PENDING_DEPTH = 32;
    localparam int POSITION_BITS = 16;
    localparam int PEND_IDX_W    = $clog2(PENDING_DEPTH);
    localparam int PEND_CNT_W    = $clog2(PENDING_DEPTH + 1);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int OFFSET_W      = 16;
    localparam int LINE_W        = 32;

    localparam logic [PEND_CNT_W-1:0]    PEND_FULL = PEND_CNT_W'(PENDING_DEPTH);
    localparam logic [PEND_CNT_W-1:0]    PEND_ONE  = PEND_CNT_W'(1);
    localparam logic [POSITION_BITS-1:0] POS_ONE   = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
    localparam logic [LINE_W-1:0]        LINE_ONE  = LINE_W'(1);
    localparam logic [QUEUE_PTR_W-1:0]   QPTR_ONE  = QUEUE_PTR_W'(1);
    localparam logic [QUEUE_CNT_W-1:0]   QCNT_ONE  = QUEUE_CNT_W'(1);
    localparam logic [QUEUE_CNT_W-1:0]   QCNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

    // Characters
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;

    // Record types
    localparam logic REC_CHAR    = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    // Roles
    localparam logic [1:0] ROLE_SECTION = 2'd0;
    localparam logic [1:0] ROLE_KEY     = 2'd1;
    localparam logic [1:0] ROLE_VALUE   = 2'd2;
    localparam logic [1:0] ROLE_COMMENT = 2'd3;

    // Line kinds
    localparam logic [2:0] KIND_COMMENT  = 3'd0;
    localparam logic [2:0] KIND_SECTION  = 3'd1;
    localparam logic [2:0] KIND_KEY      = 3'd2;
    localparam logic [2:0] KIND_MISSING  = 3'd3;
    localparam logic [2:0] KIND_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [7:0] symbol;
        logic       ends_line;
    } ilt_item_t;

    typedef struct packed {
        logic                record_type;
        logic [7:0]          out_symbol;
        logic [1:0]          role;
        logic [2:0]          line_kind;
        logic [OFFSET_W-1:0] error_offset;
        logic [LINE_W-1:0]   line_number;
        logic                last;
    } ilt_result_t;

    // Work for one accepted byte, in execution order:
    // hold whitespace, flush held whitespace, emit char, emit summary.
    typedef struct packed {
        logic                  ws_wr;
        logic [PEND_IDX_W-1:0] ws_idx;
        logic [PEND_CNT_W-1:0] flush_n;
        logic                  emit_char;
        logic [7:0]            symbol;
        logic [1:0]            role;
        logic                  emit_sum;
        logic [2:0]            kind;
        logic [OFFSET_W-1:0]   offset;
        logic [LINE_W-1:0]     line;
    } ilt_cmd_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

[sv/ini_line_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// ini_line_tokenizer_top: streaming INI line tokenizer
// Path: command queue, emitter command register, then output register.
// Throughput: one record per cycle from the emitter while the output is not
// stalled (held whitespace replays one byte a cycle); a held space makes no
// record, a dropped byte makes no command; a 4-entry queue absorbs bursts.
// Reset: asynchronous, clears line state, counters, error latch and queue.
// ----------------------------------------------------------------------------
module ini_line_tokenizer_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  ilt_pkg::ilt_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output ilt_pkg::ilt_result_t result
);
    import ilt_pkg::*;

    ilt_cmd_t cmd;
    ilt_cmd_t head;
    logic     push;
    logic     queue_full;
    logic     head_valid;
    logic     pop;

    // Classify incoming bytes
    ilt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .cmd        (cmd),
        .queue_full (queue_full)
    );

    // Decouple classifier from emitter
    ilt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Emit records
    ilt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[sv/ilt_front.sv]
// ----------------------------------------------------------------------------
// ilt_front: line classifier
// Accepts one byte per transfer, tracks the line phase, trimming state and
// positions, and turns each byte into a command for the back end.
// ----------------------------------------------------------------------------
module ilt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  ilt_pkg::ilt_item_t item,
    output logic               push,
    output ilt_pkg::ilt_cmd_t  cmd,
    input  logic               queue_full
);
    import ilt_pkg::*;

    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_COMMENT = 3'd1;
    localparam logic [2:0] PH_SECTION = 3'd2;
    localparam logic [2:0] PH_AFTER   = 3'd3;
    localparam logic [2:0] PH_KEY     = 3'd4;
    localparam logic [2:0] PH_VALUE   = 3'd5;

    logic [2:0]               phase_reg, phase_next;
    logic                     fs_reg, fs_next;
    logic [PEND_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] cend_reg, cend_next;
    logic [LINE_W-1:0]        line_reg, line_next;
    logic                     err_reg, err_next;

    logic                     ws;
    logic                     fb_active;
    logic [1:0]               fb_role;
    logic                     ovf;
    logic                     take;
    logic [POSITION_BITS-1:0] pos_inc;

    // Drop bytes silently once an error is latched
    assign item_stall = !err_reg && queue_full;
    assign take       = item_valid && !item_stall && !err_reg;
    assign push       = take && (cmd.ws_wr || cmd.emit_char || cmd.emit_sum);

    assign ws      = is_space(item.symbol);
    assign pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_ONE;

    // Classify the byte and build its command
    always_comb
    begin
        phase_next = phase_reg;
        fs_next    = fs_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        err_next   = err_reg;
        cend_next  = ws ? cend_reg : pos_inc;
        fb_active  = 1'b0;
        fb_role    = ROLE_SECTION;
        ovf        = 1'b0;
        cmd        = '0;
        cmd.symbol = item.symbol;
        cmd.line   = line_reg + LINE_ONE;

        case (phase_reg)
            PH_START:
            begin
                if (!ws)
                begin
                    if ((item.symbol == CH_HASH) || (item.symbol == CH_SEMI))
                    begin
                        phase_next    = PH_COMMENT;
                        cmd.emit_char = 1'b1;
                        cmd.role      = ROLE_COMMENT;
                        fs_next       = 1'b1;
                    end
                    else if (item.symbol == CH_LBRACK)
                    begin
                        phase_next = PH_SECTION;
                        fs_next    = 1'b0;
                    end
                    else if (item.symbol == CH_EQUAL)
                    begin
                        phase_next = PH_VALUE;
                        fs_next    = 1'b0;
                    end
                    else
                    begin
                        phase_next    = PH_KEY;
                        cmd.emit_char = 1'b1;
                        cmd.role      = ROLE_KEY;
                        fs_next       = 1'b1;
                    end
                end
            end
            PH_COMMENT:
            begin
                fb_active = 1'b1;
                fb_role   = ROLE_COMMENT;
            end
            PH_SECTION:
            begin
                if (item.symbol == CH_RBRACK)
                begin
                    phase_next = PH_AFTER;
                    cnt_next   = '0;
                    fs_next    = 1'b0;
                end
                else
                begin
                    fb_active = 1'b1;
                    fb_role   = ROLE_SECTION;
                end
            end
            PH_KEY:
            begin
                if (item.symbol == CH_EQUAL)
                begin
                    phase_next = PH_VALUE;
                    cnt_next   = '0;
                    fs_next    = 1'b0;
                end
                else
                begin
                    fb_active = 1'b1;
                    fb_role   = ROLE_KEY;
                end
            end
            PH_VALUE:
            begin
                fb_active = 1'b1;
                fb_role   = ROLE_VALUE;
            end
            default:
            begin
            end
        endcase

        // Field byte: hold inner whitespace, or flush it ahead of content
        if (fb_active)
        begin
            if (ws)
            begin
                if (fs_reg)
                begin
                    if (cnt_reg < PEND_FULL)
                    begin
                        cmd.ws_wr  = 1'b1;
                        cmd.ws_idx = cnt_reg[PEND_IDX_W-1:0];
                        cnt_next   = cnt_reg + PEND_ONE;
                    end
                    else
                    begin
                        ovf = 1'b1;
                    end
                end
            end
            else
            begin
                cmd.flush_n   = cnt_reg;
                cmd.emit_char = 1'b1;
                cmd.role      = fb_role;
                cnt_next      = '0;
                fs_next       = 1'b1;
            end
        end

        // Close the line, or report overflow at once
        if (ovf)
        begin
            cmd.emit_sum = 1'b1;
            cmd.kind     = KIND_OVERFLOW;
            cmd.offset   = OFFSET_W'(cend_next);
            err_next     = 1'b1;
            line_next    = cmd.line;
        end
        else
        begin
            pos_next = pos_inc;
            if (item.ends_line)
            begin
                case (phase_next)
                    PH_COMMENT:
                    begin
                        cmd.emit_sum = 1'b1;
                        cmd.kind     = KIND_COMMENT;
                    end
                    PH_AFTER:
                    begin
                        cmd.emit_sum = 1'b1;
                        cmd.kind     = KIND_SECTION;
                    end
                    PH_VALUE:
                    begin
                        cmd.emit_sum = 1'b1;
                        cmd.kind     = KIND_KEY;
                    end
                    PH_SECTION, PH_KEY:
                    begin
                        cmd.emit_sum = 1'b1;
                        cmd.kind     = KIND_MISSING;
                        cmd.offset   = OFFSET_W'(cend_next);
                        err_next     = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                line_next  = cmd.line;
                phase_next = PH_START;
                fs_next    = 1'b0;
                cnt_next   = '0;
                pos_next   = '0;
                cend_next  = '0;
            end
        end
    end

    // Advance line state on each taken byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            fs_reg    <= 1'b0;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            cend_reg  <= '0;
            line_reg  <= '0;
            err_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            fs_reg    <= fs_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            cend_reg  <= cend_next;
            line_reg  <= line_next;
            err_reg   <= err_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= PEND_FULL)
        else $error("held whitespace count beyond buffer depth");

    a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_START |-> cnt_reg == '0 && !fs_reg)
        else $error("line start with held whitespace or open field");

    a_flush_has_char: assert property (@(posedge clk) disable iff (!rst_n)
        push && cmd.flush_n != '0 |-> cmd.emit_char && !cmd.ws_wr)
        else $error("flush command without a content byte");
`endif

endmodule

[sv/ilt_queue.sv]
// ----------------------------------------------------------------------------
// ilt_queue: command queue
// Short FIFO between classifier and emitter so each side stalls on its own.
// ----------------------------------------------------------------------------
module ilt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ilt_pkg::ilt_cmd_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output ilt_pkg::ilt_cmd_t head
);
    import ilt_pkg::*;

    ilt_cmd_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full       = (count_reg == QCNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_ONE;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_ONE;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_ONE;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_ONE;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full command queue");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty command queue");
`endif

endmodule

[sv/ilt_back.sv]
// ----------------------------------------------------------------------------
// ilt_back: record emitter
// Executes queued commands: holds whitespace in the pending buffer, replays
// it ahead of content bytes, and drives one record per cycle unless stalled.
// ----------------------------------------------------------------------------
module ilt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  ilt_pkg::ilt_cmd_t    head,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output ilt_pkg::ilt_result_t result
);
    import ilt_pkg::*;

    localparam logic [1:0] BK_IDLE  = 2'd0;
    localparam logic [1:0] BK_FLUSH = 2'd1;
    localparam logic [1:0] BK_CHAR  = 2'd2;
    localparam logic [1:0] BK_SUM   = 2'd3;

    logic [7:0]            pend_mem [PENDING_DEPTH];
    logic [7:0]            rd_data_reg;
    ilt_cmd_t              cur_reg, cur_next;
    logic [PEND_CNT_W-1:0] idx_reg, idx_next;
    logic [1:0]            ph_reg, ph_next;
    logic                  result_valid_reg;
    ilt_result_t           result_reg;

    logic                  out_free;
    logic                  emit;
    logic                  fin;
    logic                  flush_done;
    logic [PEND_CNT_W-1:0] idx_inc;
    logic [1:0]            first_ph;
    logic                  rd_en;
    logic [PEND_IDX_W-1:0] rd_addr;
    ilt_result_t           rec;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign out_free   = !result_valid_reg || !result_stall;
    assign emit       = (ph_reg != BK_IDLE) && out_free;
    assign idx_inc    = idx_reg + PEND_ONE;
    assign flush_done = (idx_inc == cur_reg.flush_n);
    assign fin        = emit && rec.last;
    assign pop        = head_valid && ((ph_reg == BK_IDLE) || fin);

    // First step of the command at the queue head
    always_comb
    begin
        if (head.flush_n != '0)
        begin
            first_ph = BK_FLUSH;
        end
        else if (head.emit_char)
        begin
            first_ph = BK_CHAR;
        end
        else if (head.emit_sum)
        begin
            first_ph = BK_SUM;
        end
        else
        begin
            first_ph = BK_IDLE;
        end
    end

    // Build the record for the current step
    always_comb
    begin
        rec             = '0;
        rec.line_number = cur_reg.line;
        case (ph_reg)
            BK_FLUSH:
            begin
                rec.record_type = REC_CHAR;
                rec.out_symbol  = rd_data_reg;
                rec.role        = cur_reg.role;
                rec.last        = flush_done && !cur_reg.emit_char && !cur_reg.emit_sum;
            end
            BK_CHAR:
            begin
                rec.record_type = REC_CHAR;
                rec.out_symbol  = cur_reg.symbol;
                rec.role        = cur_reg.role;
                rec.last        = !cur_reg.emit_sum;
            end
            BK_SUM:
            begin
                rec.record_type  = REC_SUMMARY;
                rec.line_kind    = cur_reg.kind;
                rec.error_offset = cur_reg.offset;
                rec.last         = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Step sequencing; chain straight into the next command on the last record
    always_comb
    begin
        cur_next = cur_reg;
        idx_next = idx_reg;
        ph_next  = ph_reg;
        if (pop)
        begin
            cur_next = head;
            idx_next = '0;
            ph_next  = first_ph;
        end
        else if (fin)
        begin
            ph_next = BK_IDLE;
        end
        else if (emit)
        begin
            case (ph_reg)
                BK_FLUSH:
                begin
                    idx_next = idx_inc;
                    if (flush_done)
                    begin
                        ph_next = cur_reg.emit_char ? BK_CHAR : BK_SUM;
                    end
                end
                BK_CHAR:
                begin
                    ph_next = BK_SUM;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Prefetch the next held byte so it is ready when the slot frees
    assign rd_en   = pop || (emit && (ph_reg == BK_FLUSH) && !flush_done);
    assign rd_addr = pop ? '0 : idx_inc[PEND_IDX_W-1:0];

    // Pending whitespace buffer
    always_ff @(posedge clk)
    begin
        if (pop && head.ws_wr)
        begin
            pend_mem[head.ws_idx] <= head.symbol;
        end
        if (rd_en)
        begin
            rd_data_reg <= pend_mem[rd_addr];
        end
    end

    // Hold the current command
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= BK_IDLE;
            idx_reg <= '0;
        end
        else
        begin
            ph_reg  <= ph_next;
            idx_reg <= idx_next;
        end
    end

    // Output register: load on emit, drop once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= rec;
        end
    end

`ifndef SYNTHESIS
    a_flush_range: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg == BK_FLUSH |-> idx_reg < cur_reg.flush_n)
        else $error("whitespace replay past held count");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.record_type == REC_SUMMARY |-> result.last)
        else $error("line summary not marked last");

    a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.record_type == REC_CHAR
        |-> result.line_kind == KIND_COMMENT && result.error_offset == '0)
        else $error("character record carries summary fields");
`endif

endmodule
